// ===== src/tpp_pkg.sv =====
// Shared constants, payload types and back-end state codes for the pivot partition block.
package tpp_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned BOUND_W = 5;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PTR_W   = CNT_W + 1;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] pivot;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic [BOUND_W-1:0]       boundary;
    logic                     final_res;
  } out_item_t;

  // classified request handed from the front to the back
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] pivot;
    logic                     first;
    logic                     keep;
    logic                     last;
  } cmd_t;

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_RD   = 6'b000010,
    S_CMP  = 6'b000100,
    S_SWP  = 6'b001000,
    S_EMRD = 6'b010000,
    S_EMLD = 6'b100000
  } back_state_e;

endpackage

// ===== src/tpp_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module tpp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== src/tpp_front.sv =====
// Input side: takes requests and tags them as first of set, kept or dropped, and last.
module tpp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tpp_pkg::in_item_t in_item_i,
  output logic             push_o,
  output tpp_pkg::cmd_t    cmd_o,
  input  logic             full_i
);
  import tpp_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             keep;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  // elements beyond the store depth are dropped, but their last flag still counts
  assign keep       = (count_q < CNT_W'(DEPTH));

  always_comb begin
    cmd_o.value = in_item_i.value;
    cmd_o.pivot = in_item_i.pivot;
    cmd_o.first = (count_q == '0);
    cmd_o.keep  = keep;
    cmd_o.last  = in_item_i.last;
  end

  always_comb begin
    count_d = count_q;
    if (push_o) begin
      if (in_item_i.last) begin
        count_d = '0;
      end else if (keep) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// ===== src/tpp_queue.sv =====
// Short request queue between front and back.
module tpp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tpp_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tpp_pkg::cmd_t cmd_o
);
  import tpp_pkg::*;

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== src/tpp_back.sv =====
// Back end: loads the element store, runs the two-pointer walk and emits the set.
module tpp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  tpp_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tpp_pkg::out_item_t out_item_o
);
  import tpp_pkg::*;

  back_state_e          state_q, state_d;
  logic [CNT_W-1:0]     fill_q, fill_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [CNT_W-1:0]     k_q, k_d;
  logic [CNT_W-1:0]     lo_q, lo_d;
  logic signed [PTR_W-1:0] hi_q, hi_d;
  logic [BOUND_W-1:0]   bound_q, bound_d;
  logic signed [DATA_W-1:0] pivot_q, pivot_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_item_q, out_item_d;

  logic                 we;
  logic [IDX_W-1:0]     waddr, raddr0, raddr1;
  logic [DATA_W-1:0]    wdata, rdata0, rdata1;
  logic [CNT_W-1:0]     n_new;
  logic                 is_final;

  tpp_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(rdata0),
    .rdata1_o(rdata1)
  );

  // port 0 serves the left pointer during the walk and the emit index afterwards
  assign raddr0   = (state_q == S_EMRD || state_q == S_EMLD) ? k_q[IDX_W-1:0]
                                                             : lo_q[IDX_W-1:0];
  assign raddr1   = hi_q[IDX_W-1:0];
  assign n_new    = fill_q + CNT_W'(cmd_i.keep);
  assign is_final = (k_q == n_q - CNT_W'(1));

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    n_d         = n_q;
    k_d         = k_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    bound_d     = bound_q;
    pivot_d     = pivot_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    we          = 1'b0;
    waddr       = lo_q[IDX_W-1:0];
    wdata       = rdata1;
    pop_o       = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          if (cmd_i.first) begin
            pivot_d = cmd_i.pivot;
          end
          if (cmd_i.keep) begin
            we     = 1'b1;
            waddr  = fill_q[IDX_W-1:0];
            wdata  = cmd_i.value;
            fill_d = fill_q + CNT_W'(1);
          end
          if (cmd_i.last) begin
            n_d     = n_new;
            lo_d    = '0;
            hi_d    = $signed({1'b0, n_new}) - PTR_W'(1);
            fill_d  = '0;
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if ($signed({1'b0, lo_q}) <= hi_q) begin
          state_d = S_CMP;
        end else begin
          bound_d = (lo_q == '0) ? BOUND_W'(1) : BOUND_W'(lo_q);
          k_d     = '0;
          state_d = S_EMRD;
        end
      end
      S_CMP: begin
        if ($signed(rdata0) < pivot_q) begin
          lo_d    = lo_q + CNT_W'(1);
          state_d = S_RD;
        end else if ($signed(rdata1) >= pivot_q) begin
          hi_d    = hi_q - PTR_W'(1);
          state_d = S_RD;
        end else begin
          // right element into left slot now, left element next cycle
          we      = 1'b1;
          waddr   = lo_q[IDX_W-1:0];
          wdata   = rdata1;
          state_d = S_SWP;
        end
      end
      S_SWP: begin
        // rdata0 was sampled before the left-slot write landed, so it is the old left value
        we      = 1'b1;
        waddr   = hi_q[IDX_W-1:0];
        wdata   = rdata0;
        lo_d    = lo_q + CNT_W'(1);
        hi_d    = hi_q - PTR_W'(1);
        state_d = S_RD;
      end
      S_EMRD: begin
        state_d = S_EMLD;
      end
      S_EMLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_item_d.element   = $signed(rdata0);
          out_item_d.boundary  = bound_q;
          out_item_d.final_res = is_final;
          k_d                  = k_q + CNT_W'(1);
          state_d              = is_final ? S_LOAD : S_EMRD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      fill_q      <= '0;
      n_q         <= '0;
      k_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      bound_q     <= '0;
      pivot_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      n_q         <= n_d;
      k_q         <= k_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      bound_q     <= bound_d;
      pivot_q     <= pivot_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/two_pointer_pivot_partition.sv =====
// Pivot partition block: loads a set, partitions it around the pivot with two pointers, emits it.
// Loading: one request per cycle while the queue is not full; the back end pops and stores it.
// Partition: a pointer step goes through the read then compare state; a swap adds a write state.
// Emit: per element a store read, then the output register load, which waits on out_ready_i.
// Reset clears control state and counters; the element store holds no reset value.
// A new set's requests are queued while the previous set is still partitioning or emitting.
module two_pointer_pivot_partition (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tpp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tpp_pkg::out_item_t out_item_o
);
  import tpp_pkg::*;

  logic push, full, pop, q_valid;
  cmd_t front_cmd, back_cmd;

  tpp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i (in_item_i),
    .push_o    (push),
    .cmd_o     (front_cmd),
    .full_i    (full)
  );

  tpp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .cmd_o  (back_cmd)
  );

  tpp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (back_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule
